[sv/tun_pkg.sv]
// ----------------------------------------------------------------------------
// Triangle unit normal package
// Widths, stage counts and shared types for the triangle unit normal core.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int COORD_W    = 24;  // vertex coordinate width, Q8.16
  localparam int NFB        = 14;  // fraction bits of the normal
  localparam int OUT_W      = 16;  // width of one normal component
  localparam int NORM_TOP   = 30;  // normalized magnitudes land in [2^29, 2^30)

  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int MAG_W      = PROD_W + 1;
  localparam int A_W        = NORM_TOP;
  localparam int SQ_W       = 2 * A_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int RS_W       = SUM_W + 1;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int Q_W        = NFB + 1;
  localparam int NUM_W      = A_W + NFB + 1;

  localparam int NCHUNK     = (MAG_W + 7) / 8;
  localparam int CHUNK_W    = $clog2(NCHUNK);
  localparam int LEN_W      = $clog2(NCHUNK * 8 + 1);
  localparam int SH_W       = LEN_W + 1;

  localparam int IN_DATA_W  = ((9 * COORD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((3 * OUT_W + 7) / 8) * 8;

  localparam int Q_DEPTH    = 4;
  localparam int QA_W       = $clog2(Q_DEPTH);

  // Classified cross product: magnitudes, signs and the degenerate flag.
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic                  deg;
  } item_t;

  // Queue link between the front part, the queue and the back part.
  typedef struct packed {
    logic  valid;
    item_t item;
  } qlink_t;

  // Per-item payload carried alongside the square root and the dividers.
  typedef struct packed {
    logic [2:0][A_W-1:0] a;
    logic [2:0]          neg;
    logic                deg;
  } lane_t;

endpackage

[sv/triangle_unit_normal_core.sv]
// Pipeline: 4 front stages, the queue, 5 normalize and square stages, a sum
// stage, 31 square root stages, 16 divider stages and the output register.
// Throughput: one triangle per cycle unless stalled; the front part, the queue and
// the back part each hold their own stages, so either side can stall on its own.
// Reset: rst is synchronous and active high and clears all valid bits and queue.
// ----------------------------------------------------------------------------
// Triangle unit normal core
// Computes the unit face normal of a triangle in Q1.14 from three vertices.
// ----------------------------------------------------------------------------
module triangle_unit_normal_core (
  input  logic                           clk,
  input  logic                           rst,
  // s_tdata: v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z (lowest first)
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [tun_pkg::IN_DATA_W-1:0]  s_tdata,
  // m_tdata: norm_x, norm_y, norm_z (lowest first)
  // m_tuser: degenerate
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [tun_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tuser
);
  import tun_pkg::*;

  // The front part accepts a transaction whenever the queue has room. It
  // forms the edge vectors, the exact cross product, and splits each
  // component into magnitude and sign, flagging an all-zero cross product.
  qlink_t push;
  qlink_t head;
  logic   q_full;
  logic   pop;

  tun_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push)
  );

  // The queue decouples the two parts so that a stalled output does not
  // stop the front until the queue fills.
  tun_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (q_full),
    .head (head)
  );

  // The back part block-normalizes the magnitudes, sums their squares, takes
  // an integer square root one bit per stage, and divides each component by
  // the length with round to nearest, one quotient bit per stage. The last
  // stage is the output register, which advances whenever it is empty or
  // being taken.
  tun_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // A degenerate triangle always leaves with a zero normal.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("degenerate result with nonzero normal");

  // The first component, norm_x, stays within plus or minus one.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |->
      ($signed(m_tdata[OUT_W-1:0]) <= $signed(OUT_W'(1 << NFB)) &&
       $signed(m_tdata[OUT_W-1:0]) >= -$signed(OUT_W'(1 << NFB))))
    else $error("normal component out of range");

  // The queue is never pushed while full nor popped while empty.
  assert property (@(posedge clk) disable iff (rst)
    !(push.valid && q_full) && !(pop && !head.valid))
    else $error("queue overflow or underflow");

endmodule

[sv/tun_front.sv]
// ----------------------------------------------------------------------------
// Triangle unit normal front part
// Accepts triangles, forms edge vectors and the cross product, classifies it.
// ----------------------------------------------------------------------------
module tun_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tun_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic                          q_full,
  output tun_pkg::qlink_t               push
);
  import tun_pkg::*;

  logic                       en;
  logic [3:0]                 v;
  logic signed [COORD_W-1:0]  crd [9];
  logic signed [DIFF_W-1:0]   dn  [6];
  logic signed [DIFF_W-1:0]   d   [6];
  logic signed [PROD_W-1:0]   p   [6];
  logic signed [MAG_W-1:0]    c   [3];
  item_t                      it_next;
  item_t                      it;

  assign en       = ~q_full;
  assign s_tready = en;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      crd[i] = $signed(s_tdata[i*COORD_W +: COORD_W]);
    end
    // Edges e1 = v1 - v0 and e2 = v2 - v0.
    for (int i = 0; i < 6; i++) begin
      dn[i] = DIFF_W'(crd[i+3]) - DIFF_W'(crd[i%3]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      it_next.neg[i] = c[i][MAG_W-1];
      it_next.mag[i] = c[i][MAG_W-1] ? MAG_W'(-c[i]) : MAG_W'(c[i]);
    end
    it_next.deg = (c[0] == '0) && (c[1] == '0) && (c[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d    <= dn;
      p[0] <= d[1] * d[5];
      p[1] <= d[2] * d[4];
      p[2] <= d[2] * d[3];
      p[3] <= d[0] * d[5];
      p[4] <= d[0] * d[4];
      p[5] <= d[1] * d[3];
      c[0] <= MAG_W'(p[0]) - MAG_W'(p[1]);
      c[1] <= MAG_W'(p[2]) - MAG_W'(p[3]);
      c[2] <= MAG_W'(p[4]) - MAG_W'(p[5]);
      it   <= it_next;
    end
  end

  assign push.valid = v[3] & en;
  assign push.item  = it;

endmodule

[sv/tun_fifo.sv]
// ----------------------------------------------------------------------------
// Triangle unit normal queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module tun_fifo (
  input  logic            clk,
  input  logic            rst,
  input  tun_pkg::qlink_t push,
  input  logic            pop,
  output logic            full,
  output tun_pkg::qlink_t head
);
  import tun_pkg::*;

  item_t           mem [Q_DEPTH];
  logic [QA_W-1:0] wr;
  logic [QA_W-1:0] rd;
  logic [QA_W:0]   cnt;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr  <= '0;
      rd  <= '0;
      cnt <= '0;
    end else begin
      if (push.valid) begin
        wr <= wr + QA_W'(1);
      end
      if (pop) begin
        rd <= rd + QA_W'(1);
      end
      cnt <= cnt + (QA_W+1)'(push.valid) - (QA_W+1)'(pop);
    end
  end

  assign full       = (cnt == (QA_W+1)'(Q_DEPTH));
  assign head.valid = (cnt != '0);
  assign head.item  = mem[rd];

endmodule

[sv/tun_back.sv]
// ----------------------------------------------------------------------------
// Triangle unit normal back part
// Normalizes, takes the square root and divides, one stage per step.
// ----------------------------------------------------------------------------
module tun_back (
  input  logic                           clk,
  input  logic                           rst,
  input  tun_pkg::qlink_t                head,
  output logic                           pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [tun_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tuser
);
  import tun_pkg::*;

  logic                     en;

  logic                     b1_v, b2_v, b3_v, b4_v, b5_v;
  item_t                    b1_it, b2_it, b3_it;
  logic [NCHUNK*8-1:0]      b1_or, b2_or;
  logic [CHUNK_W-1:0]       ch_next, b2_ch;
  logic [7:0]               top_byte;
  logic [2:0]               pos;
  logic [LEN_W-1:0]         blen;
  logic signed [SH_W-1:0]   b3_sh;
  logic [SH_W-1:0]          amt;
  logic [MAG_W+A_W-1:0]     shv [3];
  lane_t                    b4_ln, b5_ln;
  logic [2:0][SQ_W-1:0]     b5_sq;

  // Square root pipeline: index 0 holds the sum of squares.
  logic                     sr_v   [ROOT_W+1];
  logic [SUM_W-1:0]         sr_rem [ROOT_W+1];
  logic [RS_W-1:0]          sr_res [ROOT_W+1];
  lane_t                    sr_ln  [ROOT_W+1];
  logic [SUM_W-1:0]         rem_next [ROOT_W];
  logic [RS_W-1:0]          res_next [ROOT_W];

  // Divider pipeline: index 0 holds the rounded numerators.
  logic                     dv_v   [Q_W+1];
  logic [2:0][NUM_W-1:0]    dv_rem [Q_W+1];
  logic [2:0][Q_W-1:0]      dv_q   [Q_W+1];
  logic [ROOT_W-1:0]        dv_len [Q_W+1];
  lane_t                    dv_ln  [Q_W+1];
  logic [2:0][NUM_W-1:0]    drem_next [Q_W];
  logic [2:0][Q_W-1:0]      dq_next   [Q_W];
  logic [ROOT_W-1:0]        len;
  logic [OUT_W-1:0]         qe [3];
  logic [OUT_DATA_W-1:0]    data_next;

  assign en  = ~m_tvalid | m_tready;
  assign pop = head.valid & en;

  // Leading-one search, first over bytes, then within the top byte.
  always_comb begin
    ch_next = '0;
    for (int c = 0; c < NCHUNK; c++) begin
      if (|b1_or[c*8 +: 8]) begin
        ch_next = CHUNK_W'(c);
      end
    end
    top_byte = b2_or[{b2_ch, 3'b000} +: 8];
    pos = '0;
    for (int b = 0; b < 8; b++) begin
      if (top_byte[b]) begin
        pos = 3'(b);
      end
    end
    blen = (|b2_or) ? (LEN_W'({b2_ch, 3'b000}) + LEN_W'(pos) + LEN_W'(1)) : '0;
  end

  always_comb begin
    amt = (b3_sh > 0) ? b3_sh : -b3_sh;
    for (int i = 0; i < 3; i++) begin
      if (b3_sh > 0) begin
        shv[i] = (MAG_W+A_W)'(b3_it.mag[i]) >> amt;
      end else begin
        shv[i] = (MAG_W+A_W)'(b3_it.mag[i]) << amt;
      end
    end
  end

  // One restoring square root step per stage.
  always_comb begin
    for (int j = 0; j < ROOT_W; j++) begin
      logic [RS_W-1:0] bitv;
      logic [RS_W-1:0] t;
      bitv = RS_W'(1) << (2 * (ROOT_W - 1 - j));
      t    = sr_res[j] + bitv;
      if (RS_W'(sr_rem[j]) >= t) begin
        rem_next[j] = sr_rem[j] - t[SUM_W-1:0];
        res_next[j] = (sr_res[j] >> 1) + bitv;
      end else begin
        rem_next[j] = sr_rem[j];
        res_next[j] = sr_res[j] >> 1;
      end
    end
  end

  assign len = sr_res[ROOT_W][ROOT_W-1:0];

  // One quotient bit per stage for each of the three components.
  always_comb begin
    for (int j = 0; j < Q_W; j++) begin
      for (int i = 0; i < 3; i++) begin
        logic [NUM_W-1:0] trial;
        trial = NUM_W'(dv_len[j]) << (Q_W - 1 - j);
        drem_next[j][i] = dv_rem[j][i];
        dq_next[j][i]   = dv_q[j][i];
        if (dv_rem[j][i] >= trial) begin
          drem_next[j][i] = dv_rem[j][i] - trial;
          dq_next[j][i]   = dv_q[j][i] | (Q_W'(1) << (Q_W - 1 - j));
        end
      end
    end
  end

  always_comb begin
    data_next = '0;
    for (int i = 0; i < 3; i++) begin
      qe[i] = OUT_W'(dv_q[Q_W][i]);
      if (dv_ln[Q_W].deg) begin
        data_next[i*OUT_W +: OUT_W] = '0;
      end else if (dv_ln[Q_W].neg[i]) begin
        data_next[i*OUT_W +: OUT_W] = -qe[i];
      end else begin
        data_next[i*OUT_W +: OUT_W] = qe[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v     <= 1'b0;
      b2_v     <= 1'b0;
      b3_v     <= 1'b0;
      b4_v     <= 1'b0;
      b5_v     <= 1'b0;
      m_tvalid <= 1'b0;
      for (int j = 0; j <= ROOT_W; j++) begin
        sr_v[j] <= 1'b0;
      end
      for (int j = 0; j <= Q_W; j++) begin
        dv_v[j] <= 1'b0;
      end
    end else if (en) begin
      b1_v    <= pop;
      b2_v    <= b1_v;
      b3_v    <= b2_v;
      b4_v    <= b3_v;
      b5_v    <= b4_v;
      sr_v[0] <= b5_v;
      for (int j = 0; j < ROOT_W; j++) begin
        sr_v[j+1] <= sr_v[j];
      end
      dv_v[0] <= sr_v[ROOT_W];
      for (int j = 0; j < Q_W; j++) begin
        dv_v[j+1] <= dv_v[j];
      end
      m_tvalid <= dv_v[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_it <= head.item;
      b1_or <= (NCHUNK*8)'(head.item.mag[0] | head.item.mag[1] | head.item.mag[2]);
      b2_it <= b1_it;
      b2_or <= b1_or;
      b2_ch <= ch_next;
      b3_it <= b2_it;
      b3_sh <= $signed({1'b0, blen}) - SH_W'(NORM_TOP);
      for (int i = 0; i < 3; i++) begin
        b4_ln.a[i] <= shv[i][A_W-1:0];
        b5_sq[i]   <= b4_ln.a[i] * b4_ln.a[i];
      end
      b4_ln.neg <= b3_it.neg;
      b4_ln.deg <= b3_it.deg;
      b5_ln     <= b4_ln;
      sr_rem[0] <= SUM_W'(b5_sq[0]) + SUM_W'(b5_sq[1]) + SUM_W'(b5_sq[2]);
      sr_res[0] <= '0;
      sr_ln[0]  <= b5_ln;
      for (int j = 0; j < ROOT_W; j++) begin
        sr_rem[j+1] <= rem_next[j];
        sr_res[j+1] <= res_next[j];
        sr_ln[j+1]  <= sr_ln[j];
      end
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= (NUM_W'(sr_ln[ROOT_W].a[i]) << NFB) + NUM_W'(len >> 1);
      end
      dv_q[0]   <= '0;
      dv_len[0] <= len;
      dv_ln[0]  <= sr_ln[ROOT_W];
      for (int j = 0; j < Q_W; j++) begin
        dv_rem[j+1] <= drem_next[j];
        dv_q[j+1]   <= dq_next[j];
        dv_len[j+1] <= dv_len[j];
        dv_ln[j+1]  <= dv_ln[j];
      end
      m_tdata <= data_next;
      m_tuser <= dv_ln[Q_W].deg;
    end
  end

endmodule
